[sv/stb_pkg.sv]
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the timer bank: table size, field widths,
// operation and result codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int NUM_TIMERS = 32;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int OP_W       = 3;
   localparam int SLOT_W     = 5;
   localparam int TICK_W     = 32;

   typedef enum logic [OP_W-1:0] {
      OP_SETUP = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_QUERY = 3'd3,
      OP_TICK  = 3'd4,
      OP_SCAN  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      K_GRANT  = 3'd0,
      K_FULL   = 3'd1,
      K_ACK    = 3'd2,
      K_QUERY  = 3'd3,
      K_EXPIRY = 3'd4,
      K_DONE   = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_READ,
      ST_SCAN_CHECK,
      ST_SCAN_DONE
   } state_type;

   typedef struct packed {
      logic exec_op;      // single-word operation taken from the request
      logic scan_start;   // rewind scan pointer
      logic scan_expire;  // expire current slot and emit a word
      logic scan_skip;    // move past current slot quietly
      logic scan_done;    // emit closing word of the scan
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_at_end;
      logic scan_hit;
   } dp_status_type;

endpackage

[sv/software_timer_bank.sv]
// ----------------------------------------------------------------------------
// software_timer_bank
// Table of one-shot timers on a shared wrapping tick counter, with setup,
// start, stop, query, tick and scan operations.
//
//   channel   ports        direction   words
//   request   req_*        in          one operation
//   response  rsp_*        out         one word, or one per expiry plus done
//
// A new request for setup, start, stop, query or tick is taken every cycle
// while the response side keeps up.
// A scan rewinds the pointer, then for each allocated slot does a registered
// deadline read, then the wrapping compare, and then the end-of-table read
// and the done word before the next request is taken.
// A stalled response holds the result register and holds back scan words.
// Reset clears the counter, allocation count and flag bits; deadlines are
// written by setup before any scan reads them, so no clearing pass.
// ----------------------------------------------------------------------------
module software_timer_bank import stb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [SLOT_W-1:0]    req_timer_index,
   input  logic signed [31:0]   req_run_length,
   input  logic                 req_wants_notify,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic                 rsp_elapsed,
   output logic                 rsp_active,
   output logic                 rsp_notify,
   output logic                 rsp_last
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   stb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   stb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_timer_index  (req_timer_index),
      .req_run_length   (req_run_length),
      .req_wants_notify (req_wants_notify),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_elapsed      (rsp_elapsed),
      .rsp_active       (rsp_active),
      .rsp_notify       (rsp_notify),
      .rsp_last         (rsp_last)
   );

endmodule

[sv/stb_ctrl.sv]
// ----------------------------------------------------------------------------
// stb_ctrl
// Controller for the timer bank: accepts request words and sequences the scan
// over allocated slots, one memory read and one check per slot.
// ----------------------------------------------------------------------------
module stb_ctrl import stb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [OP_W-1:0]      req_operation,
   output logic                 req_ready,
   input  dp_status_type        status,
   output ctrl_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (req_operation == OP_SCAN) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN_READ;
               end else begin
                  cmd.exec_op = 1'b1;
               end
            end
         end
         ST_SCAN_READ: begin
            // deadline read of the current slot is issued here
            if (status.scan_at_end) begin
               state_in = ST_SCAN_DONE;
            end else begin
               state_in = ST_SCAN_CHECK;
            end
         end
         ST_SCAN_CHECK: begin
            if (!status.scan_hit) begin
               cmd.scan_skip = 1'b1;
               state_in      = ST_SCAN_READ;
            end else if (status.out_free) begin
               cmd.scan_expire = 1'b1;
               state_in        = ST_SCAN_READ;
            end
         end
         ST_SCAN_DONE: begin
            if (status.out_free) begin
               cmd.scan_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");

   a_scan_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> state_ff == ST_SCAN_READ)
      else $error("scan start did not enter scan");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command at once");

endmodule

[sv/stb_datapath.sv]
// ----------------------------------------------------------------------------
// stb_datapath
// Datapath for the timer bank: tick counter, allocation count, per-slot
// flag bits, deadline memory with registered read, scan pointer and the
// result register.
// ----------------------------------------------------------------------------
module stb_datapath import stb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [SLOT_W-1:0]    req_timer_index,
   input  logic signed [31:0]   req_run_length,
   input  logic                 req_wants_notify,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_kind,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic                 rsp_elapsed,
   output logic                 rsp_active,
   output logic                 rsp_notify,
   output logic                 rsp_last
);

   logic [TICK_W-1:0]     tick_count_ff, tick_count_in;
   logic [CNT_W-1:0]      slots_in_use_ff, slots_in_use_in;
   logic [NUM_TIMERS-1:0] active_bits_ff, active_bits_in;
   logic [NUM_TIMERS-1:0] elapsed_bits_ff, elapsed_bits_in;
   logic [NUM_TIMERS-1:0] notify_bits_ff, notify_bits_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [TICK_W-1:0]     deadline_rd_ff;

   logic [TICK_W-1:0]     deadline_mem [NUM_TIMERS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_elapsed_ff, rsp_elapsed_in;
   logic                  rsp_active_ff, rsp_active_in;
   logic                  rsp_notify_ff, rsp_notify_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]      req_idx;
   logic [IDX_W-1:0]      scan_idx;
   logic [IDX_W-1:0]      alloc_idx;
   logic                  in_table;
   logic                  table_full;
   logic [TICK_W-1:0]     diff;
   logic                  load_out;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [TICK_W-1:0]     mem_wdata;

   assign req_idx    = IDX_W'(req_timer_index);
   assign scan_idx   = scan_idx_ff[IDX_W-1:0];
   assign alloc_idx  = slots_in_use_ff[IDX_W-1:0];
   assign in_table   = 32'(req_timer_index) < 32'(NUM_TIMERS);
   assign table_full = slots_in_use_ff >= CNT_W'(NUM_TIMERS);
   // wrapping compare: deadline reached when counter minus deadline is not negative
   assign diff       = tick_count_ff - deadline_rd_ff;
   assign load_out   = cmd.exec_op | cmd.scan_expire | cmd.scan_done;

   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.scan_at_end = scan_idx_ff >= slots_in_use_ff;
   assign status.scan_hit    = active_bits_ff[scan_idx] && !diff[TICK_W-1];

   // state update
   always_comb begin
      tick_count_in   = tick_count_ff;
      slots_in_use_in = slots_in_use_ff;
      active_bits_in  = active_bits_ff;
      elapsed_bits_in = elapsed_bits_ff;
      notify_bits_in  = notify_bits_ff;
      scan_idx_in     = scan_idx_ff;
      mem_we          = 1'b0;
      mem_waddr       = req_idx;
      mem_wdata       = tick_count_ff + TICK_W'(req_run_length);

      if (cmd.exec_op) begin
         unique case (req_operation)
            OP_SETUP: begin
               if (!table_full) begin
                  mem_we                     = 1'b1;
                  mem_waddr                  = alloc_idx;
                  mem_wdata                  = '0;
                  elapsed_bits_in[alloc_idx] = 1'b0;
                  active_bits_in[alloc_idx]  = 1'b0;
                  notify_bits_in[alloc_idx]  = req_wants_notify;
                  slots_in_use_in            = slots_in_use_ff + 1'b1;
               end
            end
            OP_START: begin
               if (in_table) begin
                  mem_we                   = 1'b1;
                  elapsed_bits_in[req_idx] = 1'b0;
                  active_bits_in[req_idx]  = 1'b1;
               end
            end
            OP_STOP: begin
               if (in_table) begin
                  active_bits_in[req_idx] = 1'b0;
               end
            end
            OP_TICK: begin
               tick_count_in = tick_count_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_start) begin
         scan_idx_in = '0;
      end
      if (cmd.scan_expire) begin
         elapsed_bits_in[scan_idx] = 1'b1;
         active_bits_in[scan_idx]  = 1'b0;
      end
      if (cmd.scan_expire || cmd.scan_skip) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
   end

   // result word
   always_comb begin
      rsp_kind_in    = K_ACK;
      rsp_slot_in    = '0;
      rsp_elapsed_in = 1'b0;
      rsp_active_in  = 1'b0;
      rsp_notify_in  = 1'b0;
      rsp_last_in    = 1'b1;
      if (cmd.scan_expire) begin
         rsp_kind_in    = K_EXPIRY;
         rsp_slot_in    = SLOT_W'(scan_idx_ff);
         rsp_elapsed_in = 1'b1;
         rsp_notify_in  = notify_bits_ff[scan_idx];
         rsp_last_in    = 1'b0;
      end else if (cmd.scan_done) begin
         rsp_kind_in = K_DONE;
      end else begin
         unique case (req_operation)
            OP_SETUP: begin
               if (table_full) begin
                  rsp_kind_in = K_FULL;
               end else begin
                  rsp_kind_in = K_GRANT;
                  rsp_slot_in = SLOT_W'(slots_in_use_ff);
               end
            end
            OP_START, OP_STOP: begin
               rsp_slot_in = req_timer_index;
            end
            OP_QUERY: begin
               rsp_kind_in    = K_QUERY;
               rsp_slot_in    = req_timer_index;
               rsp_elapsed_in = in_table && elapsed_bits_ff[req_idx];
               rsp_active_in  = in_table && active_bits_ff[req_idx];
            end
            default: begin
            end
         endcase
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         slots_in_use_ff <= '0;
         active_bits_ff  <= '0;
         elapsed_bits_ff <= '0;
         notify_bits_ff  <= '0;
         scan_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tick_count_ff   <= tick_count_in;
         slots_in_use_ff <= slots_in_use_in;
         active_bits_ff  <= active_bits_in;
         elapsed_bits_ff <= elapsed_bits_in;
         notify_bits_ff  <= notify_bits_in;
         scan_idx_ff     <= scan_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_elapsed_ff <= rsp_elapsed_in;
         rsp_active_ff  <= rsp_active_in;
         rsp_notify_ff  <= rsp_notify_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   // deadline store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[mem_waddr] <= mem_wdata;
      end
      deadline_rd_ff <= deadline_mem[scan_idx];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_elapsed = rsp_elapsed_ff;
   assign rsp_active  = rsp_active_ff;
   assign rsp_notify  = rsp_notify_ff;
   assign rsp_last    = rsp_last_ff;

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      slots_in_use_ff <= CNT_W'(NUM_TIMERS))
      else $error("allocation count beyond table");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> status.out_free)
      else $error("result register overwritten");

   a_expire_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_expire |-> status.scan_hit && !status.scan_at_end)
      else $error("expiry without a due active slot");

   a_expire_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_expire |=> !active_bits_ff[$past(scan_idx)])
      else $error("expired slot still active");

endmodule
